FILE: rtl/cfdp_pdu_header_parser_defines.svh
// Assertion macros used by the CFDP header parser checker.
`ifndef CFDP_PDU_HEADER_PARSER_DEFINES_SVH
`define CFDP_PDU_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CFDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CFDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cfdp_pkg.sv
// Types and constants for the CFDP PDU header parser.
package cfdp_pkg;

   localparam int POS_W = 5;
   localparam int LEN_W = 16;
   localparam int ID_W  = 64;

   localparam logic [7:0] VERSION_MASK   = 8'b1110_0000;
   localparam logic [7:0] SEG_CTRL_MASK  = 8'b1000_0000;
   localparam logic [7:0] ID_LEN_MASK    = 8'b0111_0000;
   localparam logic [7:0] SEG_META_MASK  = 8'b0000_1000;
   localparam logic [7:0] SEQ_LEN_MASK   = 8'b0000_0111;
   localparam logic [7:0] CRC_FLAG_MASK  = 8'b0000_0010;
   localparam logic [7:0] FLAGS_MASK     = 8'b0001_1111;

   localparam logic [POS_W-1:0] POS_FIRST  = 5'd0;
   localparam logic [POS_W-1:0] POS_LEN_HI = 5'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO = 5'd2;
   localparam logic [POS_W-1:0] POS_FOURTH = 5'd3;
   localparam logic [POS_W-1:0] FIXED_LEN  = 5'd4;

   localparam logic [LEN_W-1:0] CRC_BYTES = 16'd4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic            status;
      logic [2:0]      version;
      logic [4:0]      first_flags;
      logic [LEN_W-1:0] data_length;
      logic [1:0]      segment_flags;
      logic [3:0]      entity_id_bytes;
      logic [3:0]      sequence_bytes;
      logic [ID_W-1:0] source_id;
      logic [ID_W-1:0] sequence_number;
      logic [ID_W-1:0] destination_id;
   } rsp_type;

endpackage

FILE: rtl/cfdp_hdr_core.sv
// Header field state: byte counter, held fixed-header bytes and ID accumulators.
module cfdp_hdr_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  cfdp_pkg::req_type word,
   output logic             emit,
   output cfdp_pkg::rsp_type result
);

   logic [cfdp_pkg::POS_W-1:0]  byte_position_ff, byte_position_in;
   logic                        header_done_ff, header_done_in;
   logic [7:0]                  first_byte_held_ff, first_byte_held_in;
   logic [cfdp_pkg::LEN_W-1:0]  length_held_ff, length_held_in;
   logic [7:0]                  fourth_byte_held_ff, fourth_byte_held_in;
   logic [cfdp_pkg::ID_W-1:0]   source_acc_ff, source_acc_in;
   logic [cfdp_pkg::ID_W-1:0]   sequence_acc_ff, sequence_acc_in;
   logic [cfdp_pkg::ID_W-1:0]   dest_acc_ff, dest_acc_in;

   logic [cfdp_pkg::POS_W-1:0]  idx;
   logic [cfdp_pkg::POS_W-1:0]  pos_next;
   logic [3:0]                  id_len_cur, seq_len_cur;
   logic [3:0]                  id_len_new, seq_len_new;
   logic [cfdp_pkg::POS_W:0]    header_len;
   logic                        header_end;
   logic [7:0]                  first_masked, fourth_id, fourth_seq;

   always_comb begin
      fourth_id   = (fourth_byte_held_ff & cfdp_pkg::ID_LEN_MASK) >> 4;
      fourth_seq  = fourth_byte_held_ff & cfdp_pkg::SEQ_LEN_MASK;
      id_len_cur  = fourth_id[3:0] + 4'd1;
      seq_len_cur = fourth_seq[3:0] + 4'd1;
      idx         = byte_position_ff - cfdp_pkg::FIXED_LEN;
      pos_next    = byte_position_ff + 5'd1;

      first_byte_held_in  = first_byte_held_ff;
      length_held_in      = length_held_ff;
      fourth_byte_held_in = fourth_byte_held_ff;
      source_acc_in       = source_acc_ff;
      sequence_acc_in     = sequence_acc_ff;
      dest_acc_in         = dest_acc_ff;

      case (byte_position_ff)
         cfdp_pkg::POS_FIRST: begin
            first_byte_held_in = word.data_byte;
         end
         cfdp_pkg::POS_LEN_HI: begin
            length_held_in = {word.data_byte, length_held_ff[7:0]};
         end
         cfdp_pkg::POS_LEN_LO: begin
            length_held_in = {length_held_ff[15:8], word.data_byte};
         end
         cfdp_pkg::POS_FOURTH: begin
            fourth_byte_held_in = word.data_byte;
         end
         default: begin
            if (idx < {1'b0, id_len_cur}) begin
               source_acc_in = {source_acc_ff[cfdp_pkg::ID_W-9:0], word.data_byte};
            end else if (idx < ({1'b0, id_len_cur} + {1'b0, seq_len_cur})) begin
               sequence_acc_in = {sequence_acc_ff[cfdp_pkg::ID_W-9:0], word.data_byte};
            end else begin
               dest_acc_in = {dest_acc_ff[cfdp_pkg::ID_W-9:0], word.data_byte};
            end
         end
      endcase
   end

   always_comb begin
      id_len_new  = 4'(((fourth_byte_held_in & cfdp_pkg::ID_LEN_MASK) >> 4) + 8'd1);
      seq_len_new = 4'((fourth_byte_held_in & cfdp_pkg::SEQ_LEN_MASK) + 8'd1);
      header_len  = 6'(cfdp_pkg::FIXED_LEN) + {1'b0, id_len_new, 1'b0} + {2'b00, seq_len_new};
      header_end  = (pos_next > cfdp_pkg::FIXED_LEN) && ({1'b0, pos_next} == header_len);
      emit        = accept && !header_done_ff && (header_end || word.last_byte);
      first_masked = (first_byte_held_in & cfdp_pkg::VERSION_MASK) >> 5;

      result = '0;
      result.status = cfdp_pkg::STATUS_SHORT;
      if (header_end) begin
         result.status          = cfdp_pkg::STATUS_OK;
         result.version         = first_masked[2:0];
         result.first_flags     = 5'(first_byte_held_in & cfdp_pkg::FLAGS_MASK);
         result.data_length     = ((first_byte_held_in & cfdp_pkg::CRC_FLAG_MASK) != 8'd0)
                                  ? length_held_in - cfdp_pkg::CRC_BYTES : length_held_in;
         result.segment_flags   = {(fourth_byte_held_in & cfdp_pkg::SEG_CTRL_MASK) != 8'd0,
                                   (fourth_byte_held_in & cfdp_pkg::SEG_META_MASK) != 8'd0};
         result.entity_id_bytes = id_len_new;
         result.sequence_bytes  = seq_len_new;
         result.source_id       = source_acc_in;
         result.sequence_number = sequence_acc_in;
         result.destination_id  = dest_acc_in;
      end
   end

   always_comb begin
      byte_position_in = byte_position_ff;
      header_done_in   = header_done_ff;
      if (!header_done_ff) begin
         byte_position_in = pos_next;
         header_done_in   = header_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && word.last_byte)) begin
         byte_position_ff    <= '0;
         header_done_ff      <= 1'b0;
         first_byte_held_ff  <= '0;
         length_held_ff      <= '0;
         fourth_byte_held_ff <= '0;
         source_acc_ff       <= '0;
         sequence_acc_ff     <= '0;
         dest_acc_ff         <= '0;
      end else if (accept && !header_done_ff) begin
         byte_position_ff    <= byte_position_in;
         header_done_ff      <= header_done_in;
         first_byte_held_ff  <= first_byte_held_in;
         length_held_ff      <= length_held_in;
         fourth_byte_held_ff <= fourth_byte_held_in;
         source_acc_ff       <= source_acc_in;
         sequence_acc_ff     <= sequence_acc_in;
         dest_acc_ff         <= dest_acc_in;
      end
   end

endmodule

FILE: rtl/cfdp_pdu_header_parser.sv
// CFDP PDU header parser, one PDU byte per word with a last-byte mark.
// Latency: the result word is valid the cycle after the byte that ends the header or the marked last byte.
// Throughput: one byte per cycle unless the output register holds an unaccepted result.
// A one-entry output register; input stalls only while a result waits unaccepted.
// Reset (synchronous) clears the byte counter, held fields, accumulators and the output valid flag.
module cfdp_pdu_header_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfdp_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfdp_pkg::rsp_type rsp_word
);

   logic              rsp_valid_ff, rsp_valid_in;
   cfdp_pkg::rsp_type rsp_word_ff;
   logic              accept;
   logic              emit;
   cfdp_pkg::rsp_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   cfdp_hdr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .word   (req_word),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/cfdp_pdu_header_parser_chk.sv
// Port-level checker for the CFDP PDU header parser, bound to the top level.
`include "cfdp_pdu_header_parser_defines.svh"

module cfdp_pdu_header_parser_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cfdp_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cfdp_pkg::rsp_type rsp_word
);

   logic short_word, ok_word;

   assign short_word = rsp_valid && (rsp_word.status == cfdp_pkg::STATUS_SHORT);
   assign ok_word    = rsp_valid && (rsp_word.status == cfdp_pkg::STATUS_OK);

   `CFDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "result word dropped or changed while stalled")
   `CFDP_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output register")
   `CFDP_ASSERT_NOW(a_short_zero, clock, reset, short_word, rsp_word.version == 3'd0 && rsp_word.first_flags == 5'd0 && rsp_word.data_length == 16'd0 && rsp_word.source_id == 64'd0 && rsp_word.sequence_number == 64'd0 && rsp_word.destination_id == 64'd0, "too-short word carries nonzero fields")
   `CFDP_ASSERT_NOW(a_len_range, clock, reset, ok_word, rsp_word.entity_id_bytes >= 4'd1 && rsp_word.entity_id_bytes <= 4'd8 && rsp_word.sequence_bytes >= 4'd1 && rsp_word.sequence_bytes <= 4'd8, "decoded length out of range")
   `CFDP_ASSERT_NOW(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid, "result valid right after reset")

   logic unused_in;
   assign unused_in = req_valid ^ (^req_word);

endmodule

bind cfdp_pdu_header_parser cfdp_pdu_header_parser_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

FILE: bench/cfdp_pdu_header_parser_tb.sv
// Self-checking testbench for the CFDP PDU header parser: directed table, then random PDUs.
module cfdp_pdu_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ITEMS     = 2000;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      cfdp_pkg::req_type word;
      bit                pinned;
      cfdp_pkg::rsp_type want;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   cfdp_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   cfdp_pkg::rsp_type rsp_word;

   cfdp_pdu_header_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // parser state mirror
   logic [cfdp_pkg::POS_W-1:0] byte_pos;
   bit                         hdr_done;
   logic [7:0]                 first_held;
   logic [cfdp_pkg::LEN_W-1:0] len_held;
   logic [7:0]                 fourth_held;
   logic [cfdp_pkg::ID_W-1:0]  src_acc;
   logic [cfdp_pkg::ID_W-1:0]  seq_acc;
   logic [cfdp_pkg::ID_W-1:0]  dst_acc;

   cfdp_pkg::rsp_type header_q[$];
   dir_row_type       dir_rows[$];
   cfdp_pkg::req_type pdu_bytes[$];
   int                in_count;
   int                rsp_count;
   int                err_count;
   int                idle_cycles;
   int                burst_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic cfdp_pkg::req_type mk_word(input logic [7:0] b, input logic l);
      cfdp_pkg::req_type w;
      w.data_byte = b;
      w.last_byte = l;
      return w;
   endfunction

   task automatic clear_parser();
      byte_pos    = '0;
      hdr_done    = 1'b0;
      first_held  = '0;
      len_held    = '0;
      fourth_held = '0;
      src_acc     = '0;
      seq_acc     = '0;
      dst_acc     = '0;
   endtask

   task automatic parse_byte(input cfdp_pkg::req_type w, output bit emit,
                             output cfdp_pkg::rsp_type hdr);
      int pos;
      int e;
      int t;
      emit = 1'b0;
      hdr  = '0;
      if (!hdr_done) begin
         pos = byte_pos;
         case (byte_pos)
            cfdp_pkg::POS_FIRST:  first_held = w.data_byte;
            cfdp_pkg::POS_LEN_HI: len_held[15:8] = w.data_byte;
            cfdp_pkg::POS_LEN_LO: len_held[7:0] = w.data_byte;
            cfdp_pkg::POS_FOURTH: fourth_held = w.data_byte;
            default: begin
               e = fourth_held[6:4] + 1;
               t = fourth_held[2:0] + 1;
               if (pos - 4 < e)
                  src_acc = {src_acc[cfdp_pkg::ID_W-9:0], w.data_byte};
               else if (pos - 4 < e + t)
                  seq_acc = {seq_acc[cfdp_pkg::ID_W-9:0], w.data_byte};
               else
                  dst_acc = {dst_acc[cfdp_pkg::ID_W-9:0], w.data_byte};
            end
         endcase
         e = fourth_held[6:4] + 1;
         t = fourth_held[2:0] + 1;
         pos++;
         byte_pos = pos[cfdp_pkg::POS_W-1:0];
         if (pos > 4 && pos == 4 + 2 * e + t) begin
            hdr.status          = cfdp_pkg::STATUS_OK;
            hdr.version         = first_held[7:5];
            hdr.first_flags     = first_held[4:0];
            hdr.data_length     = (first_held & cfdp_pkg::CRC_FLAG_MASK) != 0 ?
                                  len_held - cfdp_pkg::CRC_BYTES : len_held;
            hdr.segment_flags   = {fourth_held[7], fourth_held[3]};
            hdr.entity_id_bytes = e[3:0];
            hdr.sequence_bytes  = t[3:0];
            hdr.source_id       = src_acc;
            hdr.sequence_number = seq_acc;
            hdr.destination_id  = dst_acc;
            hdr_done = 1'b1;
            emit     = 1'b1;
         end else if (w.last_byte) begin
            hdr.status = cfdp_pkg::STATUS_SHORT;
            emit       = 1'b1;
         end
      end
      if (w.last_byte)
         clear_parser();
   endtask

   task automatic cmp_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   task automatic check_header(input cfdp_pkg::rsp_type want, input cfdp_pkg::rsp_type got);
      cmp_field("status", want.status, got.status);
      cmp_field("version", want.version, got.version);
      cmp_field("first_flags", want.first_flags, got.first_flags);
      cmp_field("data_length", want.data_length, got.data_length);
      cmp_field("segment_flags", want.segment_flags, got.segment_flags);
      cmp_field("entity_id_bytes", want.entity_id_bytes, got.entity_id_bytes);
      cmp_field("sequence_bytes", want.sequence_bytes, got.sequence_bytes);
      cmp_field("source_id", want.source_id, got.source_id);
      cmp_field("sequence_number", want.sequence_number, got.sequence_number);
      cmp_field("destination_id", want.destination_id, got.destination_id);
   endtask

   always @(posedge clock) begin : monitor
      bit                emit;
      cfdp_pkg::rsp_type hdr;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            parse_byte(req_word, emit, hdr);
            if (in_count < dir_rows.size() && dir_rows[in_count].pinned)
               header_q = {header_q, dir_rows[in_count].want};
            else if (emit)
               header_q = {header_q, hdr};
            in_count++;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            rsp_count++;
            if (header_q.size() == 0) begin
               $display("%0t unexpected word: expected none actual %h", $time, rsp_word);
               err_count++;
            end else begin
               check_header(header_q.pop_front(), rsp_word);
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: stretches of full, half and quarter rate, one long hold-off
   initial begin : receiver
      int  mode;
      int  stretch;
      bit  held;
      rsp_ready = 1'b0;
      stretch   = 0;
      mode      = 0;
      held      = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (!held && rsp_count >= 20) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 2);
               stretch = $urandom_range(10, 150);
            end
            stretch--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input cfdp_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                    $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic dir_add(input logic [7:0] b, input logic l, input bit pinned,
                          input cfdp_pkg::rsp_type want);
      dir_row_type r;
      r.word   = mk_word(b, l);
      r.pinned = pinned;
      r.want   = want;
      dir_rows = {dir_rows, r};
   endtask

   // one PDU buffer: well formed with up to three trailing bytes, cut short, or loose noise
   task automatic gen_pdu(output int counted);
      cfdp_pkg::req_type w;
      int                kind;
      int                hlen;
      int                cut;
      logic [7:0]        fourth;
      pdu_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         counted = $urandom_range(1, 6);
         for (int i = 0; i < counted; i++)
            pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'($urandom_range(0, 1)))};
      end else begin
         fourth = 8'($urandom);
         hlen   = 4 + 2 * (fourth[6:4] + 1) + fourth[2:0] + 1;
         pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'b0)};
         pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'b0)};
         pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'b0)};
         pdu_bytes = {pdu_bytes, mk_word(fourth, 1'b0)};
         for (int i = 4; i < hlen; i++)
            pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'b0)};
         if (kind >= 75) begin
            cut = $urandom_range(1, hlen - 1);
            while (pdu_bytes.size() > cut)
               void'(pdu_bytes.pop_back());
            counted = cut;
         end else begin
            counted = hlen;
            repeat ($urandom_range(0, 3))
               pdu_bytes = {pdu_bytes, mk_word(8'($urandom), 1'b0)};
         end
      end
      w = pdu_bytes.pop_back();
      w.last_byte = 1'b1;
      pdu_bytes = {pdu_bytes, w};
   endtask

   initial begin : stimulus
      cfdp_pkg::rsp_type want;
      int                sent_items;
      int                counted;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      in_count    = 0;
      rsp_count   = 0;
      err_count   = 0;
      idle_cycles = 0;
      burst_left  = 0;
      sent_items  = 0;
      clear_parser();

      // single marked byte: too short
      want = '0;
      want.status = cfdp_pkg::STATUS_SHORT;
      dir_add(8'hFF, 1'b1, 1'b1, want);
      // minimum header, all zero, ends on the mark
      repeat (6) dir_add(8'h00, 1'b0, 1'b0, '0);
      want = '0;
      want.status          = cfdp_pkg::STATUS_OK;
      want.entity_id_bytes = 4'd1;
      want.sequence_bytes  = 4'd1;
      dir_add(8'h00, 1'b1, 1'b1, want);
      // all flags, crc length wraps, trailing bytes ignored
      dir_add(8'hFF, 1'b0, 1'b0, '0);
      dir_add(8'h00, 1'b0, 1'b0, '0);
      dir_add(8'h00, 1'b0, 1'b0, '0);
      dir_add(8'h88, 1'b0, 1'b0, '0);
      dir_add(8'hAA, 1'b0, 1'b0, '0);
      dir_add(8'hBB, 1'b0, 1'b0, '0);
      want = '0;
      want.status          = cfdp_pkg::STATUS_OK;
      want.version         = 3'd7;
      want.first_flags     = 5'h1F;
      want.data_length     = 16'hFFFC;
      want.segment_flags   = 2'd3;
      want.entity_id_bytes = 4'd1;
      want.sequence_bytes  = 4'd1;
      want.source_id       = 64'hAA;
      want.sequence_number = 64'hBB;
      want.destination_id  = 64'hCC;
      dir_add(8'hCC, 1'b0, 1'b1, want);
      dir_add(8'h12, 1'b0, 1'b0, '0);
      dir_add(8'h34, 1'b1, 1'b0, '0);
      // widest IDs, cut inside the source ID
      dir_add(8'h20, 1'b0, 1'b0, '0);
      dir_add(8'h12, 1'b0, 1'b0, '0);
      dir_add(8'h34, 1'b0, 1'b0, '0);
      dir_add(8'h77, 1'b0, 1'b0, '0);
      want = '0;
      want.status = cfdp_pkg::STATUS_SHORT;
      dir_add(8'h55, 1'b1, 1'b1, want);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].word);

      while (sent_items < N_ITEMS) begin
         gen_pdu(counted);
         sent_items += counted;
         foreach (pdu_bytes[i])
            send_word(pdu_bytes[i]);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (header_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (err_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
